// File: sv/urlpd_pkg.sv
// ---------------------------------------------------------------------------
// URL percent decoder package
// Shared types, character constants and the small decode helpers.
// ---------------------------------------------------------------------------
package urlpd_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	// Number of results one request leaves in the output queue.
	localparam logic [1:0] PUSH_NONE = 2'd0;
	localparam logic [1:0] PUSH_ONE  = 2'd1;
	localparam logic [1:0] PUSH_TWO  = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} urlpd_item_t;

	typedef struct packed {
		logic [1:0]  count;
		urlpd_item_t first;
		urlpd_item_t second;
	} urlpd_push_t;

	// Returns {is_hex, value}.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CH_0 && c <= CH_9) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
			// Letters a..f and A..F both have low nibble 1..6.
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

	function automatic logic [7:0] plain_byte(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

endpackage

// File: sv/urlpd_if.sv
// ---------------------------------------------------------------------------
// URL percent decoder stream interfaces
// Valid/ready channels for the raw input bytes and the decoded bytes.
// ---------------------------------------------------------------------------
interface urlpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface urlpd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: sv/urlpd_fifo.sv
// ---------------------------------------------------------------------------
// URL percent decoder result queue
// Small register queue that takes up to two results a cycle and gives one.
// ---------------------------------------------------------------------------
module urlpd_fifo
	import urlpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  urlpd_push_t       push,
	input  logic              pop,
	output urlpd_item_t       head,
	output logic              not_empty,
	output logic [CNT_W-1:0]  fill
);

	urlpd_item_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign fill      = count_q;

	always_ff @(posedge clk) begin
		if (push.count != PUSH_NONE) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == PUSH_TWO) begin
			mem_q[PTR_W'(wr_ptr_q + 1'b1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(push.count));
			if (do_pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= CNT_W'(count_q + CNT_W'(push.count) - CNT_W'(do_pop));
		end
	end

endmodule

// File: sv/url_percent_decoder.sv
// ---------------------------------------------------------------------------
// URL percent decoder
// Streams one URL-encoded text a byte at a time and emits decoded bytes.
// ---------------------------------------------------------------------------
//  channel | dir | payload            | accepted when
//  din     | in  | in_byte, in_last   | din.valid && din.ready
//  dout    | out | out_byte, out_last | dout.valid && dout.ready
//
// One byte is accepted per cycle while din.ready is high. A byte is registered
// in the input register, where the escape state decides its results, and is
// then written into a four-entry result queue that drives dout. The input
// register advances only while the queue holds at most two entries, so a
// stall on dout backs up into din.ready. Reset clears the escape state, the
// input register valid and the queue.
// ---------------------------------------------------------------------------
module url_percent_decoder
	import urlpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	urlpd_in_if.sink   din,
	urlpd_out_if.source dout
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic [1:0]        phase_q;
	logic [7:0]        held_q;
	logic [1:0]        phase_d;
	logic [CNT_W-1:0]  fill;
	logic              advance;
	logic              take;
	logic [4:0]        hex_held;
	logic [4:0]        hex_cur;
	logic [7:0]        esc_val;
	urlpd_push_t       push;
	urlpd_item_t       head;
	logic              not_empty;

	assign advance   = valid_s1 && (fill <= CNT_W'(FIFO_DEPTH - 2));
	assign din.ready = !valid_s1 || advance;
	assign take      = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= din.in_byte;
			last_s1 <= din.in_last;
		end
	end

	assign hex_held = hex_digit(held_q);
	assign hex_cur  = hex_digit(byte_s1);

	always_comb begin
		esc_val = '0;
		if (hex_held[4]) begin
			esc_val = hex_cur[4] ? {hex_held[3:0], hex_cur[3:0]} : {4'd0, hex_held[3:0]};
		end
	end

	always_comb begin
		push         = '0;
		phase_d      = PH_IDLE;
		push.first   = '{data: plain_byte(byte_s1), last: last_s1};
		push.second  = '{data: plain_byte(byte_s1), last: 1'b1};
		unique case (phase_q)
			PH_PCT: begin
				if (last_s1) begin
					// Text ended right after the percent sign: both go out literally.
					push.count = PUSH_TWO;
					push.first = '{data: CH_PCT, last: 1'b0};
				end else begin
					phase_d = PH_DIGIT;
				end
			end
			PH_DIGIT: begin
				push.count = PUSH_ONE;
				push.first = '{data: esc_val, last: last_s1};
			end
			default: begin
				if (byte_s1 == CH_PCT && !last_s1) begin
					phase_d = PH_PCT;
				end else begin
					push.count = PUSH_ONE;
				end
			end
		endcase
		if (!advance) begin
			push.count = PUSH_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			if (phase_q == PH_PCT) begin
				held_q <= byte_s1;
			end
		end
	end

	urlpd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (dout.ready),
		.head      (head),
		.not_empty (not_empty),
		.fill      (fill)
	);

	assign dout.valid    = not_empty;
	assign dout.out_byte = head.data;
	assign dout.out_last = head.last;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (phase_q == PH_IDLE))
		else $error("escape state survives the end of a text");

	a_hold_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_PCT && !last_s1) |=>
		(held_q == $past(byte_s1) && phase_q == PH_DIGIT))
		else $error("first escape digit not held");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(last_s1)))
		else $error("stalled input stage lost its byte");

endmodule
